FILE: hdl/fef_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the feedback echo filter.
package fef_pkg;

	localparam int MaxDelay = 8192;
	localparam int AddrW    = $clog2(MaxDelay);
	localparam int CntW     = $clog2(MaxDelay + 1);
	localparam int LenW     = 14;
	localparam int WeightW  = 16;
	localparam int SampleW  = 64;
	localparam int CmpW     = (LenW > CntW) ? LenW : CntW;
	localparam int PaddrW   = 4;
	localparam int PdataW   = 32;

	localparam logic [SampleW-1:0] Offset = {1'b1, {(SampleW-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_WEIGHT = 2'd0,
		REG_DELAY  = 2'd1,
		REG_SIZE   = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		SZ_8  = 2'd0,
		SZ_16 = 2'd1,
		SZ_32 = 2'd2,
		SZ_64 = 2'd3
	} size_code_t;

	typedef struct packed {
		logic signed [WeightW-1:0] weight;
		logic [LenW-1:0]           delay_len;
		size_code_t                size;
	} fef_cfg_t;

	typedef struct packed {
		logic [SampleW-1:0] lo_off;
		logic [SampleW-1:0] hi_off;
	} bounds_t;

	// Offset-binary limits of the signed range for a sample width.
	function automatic bounds_t size_bounds(input size_code_t code);
		bounds_t            b;
		logic [SampleW-1:0] half;
		unique case (code)
			SZ_8:    half = SampleW'(1) << 7;
			SZ_16:   half = SampleW'(1) << 15;
			SZ_32:   half = SampleW'(1) << 31;
			SZ_64:   half = SampleW'(1) << 63;
			default: half = SampleW'(1) << 15;
		endcase
		b.lo_off = Offset - half;
		b.hi_off = Offset + (half - SampleW'(1));
		return b;
	endfunction

endpackage

FILE: hdl/fef_regs.sv
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
module fef_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fef_pkg::PaddrW-1:0]  paddr,
	input  logic [fef_pkg::PdataW-1:0]  pwdata,
	output logic [fef_pkg::PdataW-1:0]  prdata,
	output logic                        pready,
	output fef_pkg::fef_cfg_t           cfg
);
	import fef_pkg::*;

	logic signed [WeightW-1:0] weight_q;
	logic [LenW-1:0]           delay_len_q;
	size_code_t                size_q;
	reg_idx_t                  idx;
	logic                      wr;

	assign idx    = reg_idx_t'(paddr[PaddrW-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= WeightW'(8192);
			delay_len_q <= LenW'(1);
			size_q      <= SZ_16;
		end else if (wr) begin
			unique case (idx)
				REG_WEIGHT: weight_q    <= pwdata[WeightW-1:0];
				REG_DELAY:  delay_len_q <= pwdata[LenW-1:0];
				REG_SIZE:   size_q      <= size_code_t'(pwdata[1:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WEIGHT: prdata = PdataW'(unsigned'(weight_q));
			REG_DELAY:  prdata = PdataW'(delay_len_q);
			REG_SIZE:   prdata = PdataW'(size_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.weight    = weight_q;
	assign cfg.delay_len = delay_len_q;
	assign cfg.size      = size_q;

endmodule

FILE: hdl/feedback_echo_filter.sv
`timescale 1ns / 1ps
// Top level of the feedback comb echo filter: delay memory and arithmetic pipeline.
// Each accepted sample yields one result after a delay read, partial products, a product
// sum, then add and saturate into the output register. The block takes one sample per
// cycle, unless the output stalls, during the fill phase and whenever the delay length
// is four or more; with a shorter delay a sample that reads an entry still being computed
// waits for its write-back. The delay line is a single 8192 x 64 memory with one read
// and one write port; it needs no clearing after reset, since, while the delay length
// is not raised mid-stream, the fill phase writes every entry before it is read.
module feedback_echo_filter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [fef_pkg::PaddrW-1:0]        paddr,
	input  logic [fef_pkg::PdataW-1:0]        pwdata,
	output logic [fef_pkg::PdataW-1:0]        prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [fef_pkg::SampleW-1:0] sample_in,
	input  logic                              stream_start,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fef_pkg::SampleW-1:0] sample_out,
	output logic                              saturated
);
	import fef_pkg::*;

	fef_cfg_t cfg;

	fef_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stream position
	logic [AddrW-1:0] ptr_q, ptr_base, ptr_cur, ptr_next;
	logic [CntW-1:0]  fill_q, fill_base, fill_next, d_eff, ptr_inc;
	logic [CmpW-1:0]  len_ext;
	logic             is_fill, hazard, adv, accept;

	// Pipeline
	logic                v_s1, v_s2, v_s3, out_valid_q;
	logic                fill_s1, fill_s2;
	logic [SampleW-1:0]  x_s1, x_s2, x_s3;
	logic [AddrW-1:0]    ptr_s1, ptr_s2, ptr_s3;
	logic [SampleW-1:0]  rd_q;
	logic [47:0]         ph_s2, pl_s2;
	logic                neg_s2;
	logic [SampleW-1:0]  q_s3;
	logic                huge_s3, neg_s3;
	logic [SampleW-1:0]  sample_out_q;
	logic                saturated_q;

	logic [SampleW-1:0]  mem [MaxDelay];

	always_comb begin
		len_ext = CmpW'(cfg.delay_len);
		if (len_ext == '0) begin
			d_eff = CntW'(1);
		end else if (len_ext > CmpW'(MaxDelay)) begin
			d_eff = CntW'(MaxDelay);
		end else begin
			d_eff = len_ext[CntW-1:0];
		end
	end

	assign ptr_base  = stream_start ? '0 : ptr_q;
	assign fill_base = stream_start ? '0 : fill_q;
	assign ptr_cur   = (CntW'(ptr_base) >= d_eff) ? '0 : ptr_base;
	assign is_fill   = fill_base < d_eff;
	assign ptr_inc   = CntW'(ptr_cur) + CntW'(1);
	assign ptr_next  = (ptr_inc >= d_eff) ? '0 : ptr_inc[AddrW-1:0];
	assign fill_next = is_fill ? fill_base + CntW'(1) : fill_base;

	assign adv = !out_valid_q || !out_stall;

	// Interlock: a read waits until an in-flight write to the same entry has landed.
	assign hazard = !is_fill && ((v_s1 && ptr_s1 == ptr_cur) ||
		(v_s2 && ptr_s2 == ptr_cur) || (v_s3 && ptr_s3 == ptr_cur));

	assign in_stall = !adv || hazard;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			ptr_q  <= ptr_next;
			fill_q <= fill_next;
		end
	end

	// Stage 1: magnitudes and partial products
	logic [SampleW-1:0]  ym;
	logic [WeightW-1:0]  wm;
	logic                yneg, wneg;
	logic [47:0]         ph_c, pl_c;

	assign yneg = rd_q[SampleW-1];
	assign ym   = yneg ? (~rd_q + SampleW'(1)) : rd_q;
	assign wneg = cfg.weight[WeightW-1];
	assign wm   = wneg ? (~cfg.weight + WeightW'(1)) : cfg.weight;
	assign ph_c = ym[63:32] * wm;
	assign pl_c = ym[31:0] * wm;

	// Stage 2: sum of shifted partial products
	logic [SampleW:0]   qsum;
	logic [SampleW-1:0] q_c;
	logic               huge_c, neg_c;

	assign qsum   = {1'b0, ph_s2[45:0], 18'b0} + (SampleW + 1)'(pl_s2[47:14]);
	assign huge_c = !fill_s2 && ((ph_s2[47:46] != 2'b00) || qsum[SampleW]);
	assign q_c    = fill_s2 ? '0 : qsum[SampleW-1:0];
	assign neg_c  = !fill_s2 && neg_s2 && (huge_c || q_c != '0);

	// Stage 3: add in offset binary and saturate
	bounds_t            bnd;
	logic [SampleW-1:0] xu, t_c, t_sat;
	logic [SampleW:0]   sum65, dif65;
	logic               over, under, wr_en;

	assign bnd   = size_bounds(cfg.size);
	assign xu    = x_s3 ^ Offset;
	assign sum65 = {1'b0, xu} + {1'b0, q_s3};
	assign dif65 = {1'b0, xu} - {1'b0, q_s3};

	always_comb begin
		over  = 1'b0;
		under = 1'b0;
		t_c   = xu;
		if (huge_s3) begin
			over  = !neg_s3;
			under = neg_s3;
		end else if (!neg_s3) begin
			t_c  = sum65[SampleW-1:0];
			over = sum65[SampleW];
		end else begin
			t_c   = dif65[SampleW-1:0];
			under = dif65[SampleW];
		end
		if (!over && !under) begin
			if (t_c > bnd.hi_off) begin
				over = 1'b1;
			end else if (t_c < bnd.lo_off) begin
				under = 1'b1;
			end
		end
		if (over) begin
			t_sat = bnd.hi_off;
		end else if (under) begin
			t_sat = bnd.lo_off;
		end else begin
			t_sat = t_c;
		end
	end

	assign wr_en = adv && v_s3;

	always_ff @(posedge clk) begin
		if (accept && !is_fill) begin
			rd_q <= mem[ptr_cur];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_s3] <= t_sat ^ Offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= accept;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fill_s1      <= is_fill;
			x_s1         <= sample_in;
			ptr_s1       <= ptr_cur;
			ph_s2        <= ph_c;
			pl_s2        <= pl_c;
			neg_s2       <= wneg != yneg;
			fill_s2      <= fill_s1;
			x_s2         <= x_s1;
			ptr_s2       <= ptr_s1;
			q_s3         <= q_c;
			huge_s3      <= huge_c;
			neg_s3       <= neg_c;
			x_s3         <= x_s2;
			ptr_s3       <= ptr_s2;
			sample_out_q <= t_sat ^ Offset;
			saturated_q  <= over || under;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign saturated  = saturated_q;

`ifndef SYNTH
	logic [SampleW-1:0] out_off;
	assign out_off = sample_out_q ^ Offset;

	a_out_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_off >= bnd.lo_off && out_off <= bnd.hi_off))
		else $error("result outside the configured sample range");

	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && saturated_q |-> (out_off == bnd.hi_off || out_off == bnd.lo_off))
		else $error("clipped result not at a range bound");

	a_no_stale_read: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !fill_s1 |-> !(v_s2 && ptr_s2 == ptr_s1) && !(v_s3 && ptr_s3 == ptr_s1))
		else $error("delay entry read before its pending write-back");

	a_ptr_in_delay: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> CntW'(ptr_q) < d_eff)
		else $error("delay pointer beyond delay length");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the feedback comb echo filter: directed table, then random phases.
module tb;
	import fef_pkg::*;

	typedef struct packed {
		logic [SampleW-1:0] value;
		logic               clipped;
	} echo_t;

	typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;
	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_t;

	typedef struct {
		row_kind_t          kind;
		reg_idx_t           idx;
		logic [PdataW-1:0]  wdata;
		logic [SampleW-1:0] smp;
		logic               strt;
		logic               typed;
		echo_t              want;
	} plan_row_t;

	logic                      clk          = 1'b0;
	logic                      arst_n       = 1'b0;
	logic                      psel         = 1'b0;
	logic                      penable      = 1'b0;
	logic                      pwrite       = 1'b0;
	logic [PaddrW-1:0]         paddr        = '0;
	logic [PdataW-1:0]         pwdata       = '0;
	logic [PdataW-1:0]         prdata;
	logic                      pready;
	logic                      in_valid     = 1'b0;
	logic                      in_stall;
	logic signed [SampleW-1:0] sample_in    = '0;
	logic                      stream_start = 1'b0;
	logic                      out_valid;
	logic                      out_stall    = 1'b0;
	logic signed [SampleW-1:0] sample_out;
	logic                      saturated;

	// model of the filter state and registers
	logic [SampleW-1:0] echo_line [MaxDelay];
	bit                 line_written [MaxDelay];
	int unsigned        line_ptr   = 0;
	int unsigned        fill_taken = 0;
	logic signed [WeightW-1:0] cfg_weight = 16'sd8192;
	logic [LenW-1:0]    cfg_delay  = 14'd1;
	size_code_t         cfg_size   = SZ_16;

	echo_t     echoes_due [$];
	echo_t     head;
	plan_row_t plan [$];
	int        bad_echoes    = 0;
	int        send_idle_pct = 0;
	int        stall_pct     = 0;

	feedback_echo_filter dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_in   (sample_in),
		.stream_start(stream_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.sample_out  (sample_out),
		.saturated   (saturated)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(40_000_000);
		$display("Verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (bad_echoes < 100)
			$display("MISMATCH at %0t: %s", $realtime, what);
		bad_echoes++;
	endtask

	function automatic int unsigned eff_delay();
		if (cfg_delay < 1)
			return 1;
		if (cfg_delay > MaxDelay)
			return MaxDelay;
		return cfg_delay;
	endfunction

	// True when a sample without a stream start would read a line entry never written.
	function automatic bit reads_unwritten();
		int unsigned d;
		int unsigned p;
		d = eff_delay();
		p = (line_ptr >= d) ? 0 : line_ptr;
		return fill_taken >= d && !line_written[p];
	endfunction

	function automatic echo_t echo_of(input logic signed [SampleW-1:0] x, input logic strt);
		echo_t                r;
		int unsigned          d;
		int unsigned          width;
		logic                 fill;
		logic                 neg;
		logic                 huge;
		logic [SampleW-1:0]   y;
		logic [SampleW-1:0]   ym;
		logic [16:0]          wm;
		logic [80:0]          prod;
		logic [66:0]          q;
		logic signed [67:0]   total;
		logic signed [67:0]   hi;
		logic signed [67:0]   lo;
		if (strt) begin
			fill_taken = 0;
			line_ptr   = 0;
		end
		d = eff_delay();
		if (line_ptr >= d)
			line_ptr = 0;
		fill = fill_taken < d;
		q    = '0;
		neg  = 1'b0;
		huge = 1'b0;
		if (!fill) begin
			y    = echo_line[line_ptr];
			ym   = y[63] ? -y : y;
			wm   = cfg_weight[WeightW-1] ? 17'(-int'(cfg_weight)) : 17'(cfg_weight);
			prod = 81'(ym) * 81'(wm);
			// truncate toward zero on the magnitude
			q    = prod[80:14];
			huge = |q[66:64];
			neg  = y[63] ^ cfg_weight[WeightW-1];
			if (!huge && q == '0)
				neg = 1'b0;
		end
		width = 8 << cfg_size;
		hi    = (68'sd1 <<< (width - 1)) - 68'sd1;
		lo    = -(68'sd1 <<< (width - 1));
		total = x;
		if (neg)
			total = total - $signed({1'b0, q});
		else
			total = total + $signed({1'b0, q});
		r.clipped = 1'b1;
		if (huge)
			r.value = neg ? lo[63:0] : hi[63:0];
		else if (total > hi)
			r.value = hi[63:0];
		else if (total < lo)
			r.value = lo[63:0];
		else begin
			r.value   = total[63:0];
			r.clipped = 1'b0;
		end
		echo_line[line_ptr]    = r.value;
		line_written[line_ptr] = 1'b1;
		line_ptr = (line_ptr + 1 >= d) ? 0 : line_ptr + 1;
		if (fill)
			fill_taken++;
		return r;
	endfunction

	function automatic logic [SampleW-1:0] draw_sample(input size_code_t sz);
		logic [SampleW-1:0] raw;
		logic [SampleW-1:0] hi;
		int unsigned        w;
		int unsigned        pick;
		raw  = {$urandom, $urandom};
		w    = 8 << sz;
		hi   = (64'd1 << (w - 1)) - 64'd1;
		pick = $urandom_range(99);
		if (pick < 12)
			return raw;
		if (pick < 20) begin
			case ($urandom_range(5))
				0: return hi;
				1: return ~hi;
				2: return hi + 64'd1;
				3: return ~hi - 64'd1;
				4: return '0;
				default: return 64'h7FFF_FFFF_FFFF_FFFF;
			endcase
		end
		return $signed(raw << (64 - w)) >>> (64 - w);
	endfunction

	function automatic void plan_cfg(input reg_idx_t idx, input logic [PdataW-1:0] v);
		plan_row_t row;
		row = '{ROW_CFG, idx, v, 64'd0, 1'b0, 1'b0, echo_t'(0)};
		plan.insert(plan.size(), row);
	endfunction

	function automatic void plan_sample(input logic [SampleW-1:0] smp, input logic strt,
		input logic typed, input logic [SampleW-1:0] val, input logic clip);
		plan_row_t row;
		row = '{ROW_SAMPLE, REG_WEIGHT, '0, smp, strt, typed, echo_t'({val, clip})};
		plan.insert(plan.size(), row);
	endfunction

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:  begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SEND:  begin send_idle_pct = 76; stall_pct = 0;  end
			IDLE_STALL: begin send_idle_pct = 0;  stall_pct = 76; end
			default:    begin send_idle_pct = 10; stall_pct = 10; end
		endcase
	endtask

	// Hold the input side until every pending echo has come back.
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (echoes_due.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [PdataW-1:0] v);
		logic [PdataW-1:0] mask;
		logic [PdataW-1:0] readback;
		case (idx)
			REG_WEIGHT: mask = 32'h0000_FFFF;
			REG_DELAY:  mask = 32'h0000_3FFF;
			default:    mask = 32'h0000_0003;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PaddrW'({idx, 2'b00});
		pwdata  <= v;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_WEIGHT: cfg_weight = v[WeightW-1:0];
			REG_DELAY:  cfg_delay  = v[LenW-1:0];
			default:    cfg_size   = size_code_t'(v[1:0]);
		endcase
		if ((readback & mask) !== (v & mask))
			flag_mismatch($sformatf("register %s reads %h, wrote %h", idx.name(),
				readback & mask, v & mask));
	endtask

	task automatic send_sample(input logic [SampleW-1:0] smp, input logic strt_req,
		input logic typed, input echo_t want);
		echo_t got;
		logic  strt;
		// restart the stream rather than read a line entry never written
		strt = strt_req || reads_unwritten();
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid     <= 1'b1;
		sample_in    <= smp;
		stream_start <= strt;
		do @(posedge clk); while (in_stall);
		got = echo_of(smp, strt);
		echoes_due.insert(echoes_due.size(), typed ? want : got);
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [WeightW-1:0] w, input logic [LenW-1:0] d,
		input size_code_t sz, input idle_mode_t mode, input int count, input int start_pct);
		logic strt;
		settle();
		write_reg(REG_WEIGHT, PdataW'(w));
		write_reg(REG_DELAY, PdataW'(d));
		write_reg(REG_SIZE, PdataW'(sz));
		set_idling(mode);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				settle();
			if (i == 0)
				strt = start_pct == 0 || $urandom_range(1) == 1;
			else
				strt = $urandom_range(99) < start_pct;
			send_sample(draw_sample(sz), strt, 1'b0, echo_t'(0));
		end
	endtask

	always @(negedge clk)
		out_stall <= $urandom_range(99) < stall_pct;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (echoes_due.size() == 0)
				flag_mismatch($sformatf("echo %h with none pending", sample_out));
			else begin
				head = echoes_due.pop_front();
				if (sample_out !== head.value)
					flag_mismatch($sformatf("sample_out %h, predicted %h", sample_out, head.value));
				if (saturated !== head.clipped)
					flag_mismatch($sformatf("saturated %b, predicted %b", saturated, head.clipped));
			end
		end
	end

	initial begin
		// reset registers: weight 0.5, delay 1, 16-bit samples
		plan_sample(64'd1000, 1'b1, 1'b1, 64'd1000, 1'b0);
		plan_sample(64'd0, 1'b0, 1'b1, 64'd500, 1'b0);
		plan_sample(64'd32767, 1'b0, 1'b1, 64'd32767, 1'b1);
		plan_sample(-64'sd32768, 1'b0, 1'b0, '0, 1'b0);
		plan_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, 64'd32767, 1'b1);
		plan_sample(64'h8000_0000_0000_0000, 1'b0, 1'b1, -64'sd32768, 1'b1);
		plan_sample(-64'sd1, 1'b1, 1'b1, -64'sd1, 1'b0);
		// minus one half truncates to zero
		plan_sample(64'd0, 1'b0, 1'b1, 64'd0, 1'b0);
		// weight -2.0, full 64-bit samples, delay zero acts as one
		plan_cfg(REG_WEIGHT, 32'h0000_8000);
		plan_cfg(REG_SIZE, PdataW'(SZ_64));
		plan_cfg(REG_DELAY, 32'd0);
		plan_sample(64'h4000_0000_0000_0000, 1'b1, 1'b1, 64'h4000_0000_0000_0000, 1'b0);
		plan_sample(64'd0, 1'b0, 1'b0, '0, 1'b0);
		// weighted term alone overflows 64 bits
		plan_sample(-64'sd1, 1'b0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
		plan_sample(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0, 1'b0);
		// weight near +2.0, 8-bit samples, out-of-range input clips during fill
		plan_cfg(REG_WEIGHT, 32'h0000_7FFF);
		plan_cfg(REG_SIZE, PdataW'(SZ_8));
		plan_cfg(REG_DELAY, 32'd4);
		plan_sample(64'd127, 1'b1, 1'b1, 64'd127, 1'b0);
		plan_sample(-64'sd128, 1'b0, 1'b1, -64'sd128, 1'b0);
		plan_sample(64'd300, 1'b0, 1'b1, 64'd127, 1'b1);
		plan_sample(-64'sd300, 1'b0, 1'b1, -64'sd128, 1'b1);
		plan_sample(64'd0, 1'b0, 1'b0, '0, 1'b0);
		plan_sample(-64'sd5, 1'b0, 1'b0, '0, 1'b0);
		// shorten below the pointer: it wraps to the start
		plan_cfg(REG_DELAY, 32'd2);
		plan_sample(64'd3, 1'b0, 1'b0, '0, 1'b0);
		plan_sample(-64'sd3, 1'b0, 1'b0, '0, 1'b0);
		// lengthen mid-stream: one more pass-through before echoes resume
		plan_cfg(REG_DELAY, 32'd5);
		plan_sample(64'd77, 1'b0, 1'b1, 64'd77, 1'b0);
		plan_sample(64'd1, 1'b0, 1'b0, '0, 1'b0);
		plan_sample(64'd2, 1'b0, 1'b0, '0, 1'b0);
		plan_sample(64'd3, 1'b0, 1'b0, '0, 1'b0);

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(IDLE_BOTH);
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				settle();
				write_reg(plan[i].idx, plan[i].wdata);
			end else
				send_sample(plan[i].smp, plan[i].strt, plan[i].typed, plan[i].want);
		end

		run_phase(16'sd8192, 14'd3, SZ_16, IDLE_NONE, 80, 2);
		run_phase(-16'sd8192, 14'd1, SZ_8, IDLE_SEND, 80, 2);
		run_phase(16'sd32767, 14'd37, SZ_32, IDLE_STALL, 80, 2);
		run_phase(-16'sd32768, 14'd20, SZ_64, IDLE_BOTH, 80, 2);
		run_phase(16'($urandom), 14'($urandom_range(1, 64)), size_code_t'($urandom_range(3)),
			IDLE_SEND, 80, 2);
		run_phase(16'($urandom), 14'($urandom_range(0, 6)), size_code_t'($urandom_range(3)),
			IDLE_STALL, 80, 2);
		run_phase(16'($urandom), 14'($urandom_range(1, 16)), size_code_t'($urandom_range(3)),
			IDLE_BOTH, 80, 2);
		// delay above the line depth clamps to the depth: the phase stays in fill
		run_phase(16'sd16384, 14'd16383, SZ_16, IDLE_NONE, 60, 0);
		run_phase(-16'sd16384, 14'd8192, SZ_32, IDLE_BOTH, 60, 1);
		run_phase(-16'sd1, 14'd0, SZ_64, IDLE_NONE, 60, 2);

		settle();
		repeat (20) @(negedge clk);
		if (bad_echoes == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
